// ===== rtl/core/waf_pkg.sv =====
`timescale 1ns / 1ps

package waf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TERM_W      = 18;  // widest per-sample term, deviation up to 65535
  localparam int CFG_INDEX_W = 8;
  localparam int DEF_LEN_REQ = 8;

  // x / 5 for 0 <= x <= 2^17 as (x * 52429) >> 18, exact over that range
  localparam logic [15:0] FIFTH_MUL   = 16'd52429;
  localparam int          FIFTH_SHIFT = 18;
  localparam int          PROD_W      = TERM_W + 16;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_KIND  = 8'd1;

  typedef enum logic [1:0] {
    KIND_PLAIN     = 2'd0,
    KIND_WEIGHTED  = 2'd1,
    KIND_DEVIATION = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_HALF,
    CLS_FIFTH,
    CLS_FULL
  } class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/windowed_average_filter.sv =====
`timescale 1ns / 1ps

// Moving average over the last window_length signed 16-bit samples, with three result
// kinds: plain mean, mean weighted by thirds (oldest third halved, middle third times
// 4/5) and mean absolute deviation from the reference carried with each sample. Every
// input transfer yields exactly one output transfer. The samples live in a circular
// buffer in a single-port synchronous RAM of MAX_WINDOW entries; slots not yet filled
// since the last length write read as zero, so no clearing pass is needed. An item
// goes from its input transfer to the output register by one RAM read per window
// entry through a three stage read/scale/accumulate pipe, then a restoring divider
// over the ACC_W = 18 + clog2(MAX_WINDOW) bit sum that retires one quotient bit per
// cycle. The block takes one item at a time; a finished result sits in the output
// register, so the next sample is taken while it waits. Configuration writes are
// taken while no item is in flight; a window_length write resets the window.
module windowed_average_filter
  import waf_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // sample stream in
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [31:0]                               s_axis_tdata,  // [15:0] sample, [31:16] reference
  // result stream out
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [15:0]                               m_axis_tdata,  // [15:0] average
  // register write channel
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                    cfg_index,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]         cfg_data
);

  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W  = $clog2(MAX_WINDOW);
  localparam int ACC_W   = TERM_W + ADDR_W;
  localparam int DCNT_W  = $clog2(ACC_W);
  localparam int DEF_LEN = (DEF_LEN_REQ <= MAX_WINDOW) ? DEF_LEN_REQ : MAX_WINDOW;

  // control state
  state_t              state, state_next;
  logic [LEN_W-1:0]    window_length;
  kind_t               average_kind;
  logic [LEN_W-1:0]    fill_count;
  logic [ADDR_W-1:0]   head;               // physical slot of the oldest sample once full

  // sample store
  logic signed [SAMPLE_W-1:0] window_store [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] mem_rdata;
  logic signed [SAMPLE_W-1:0] ref_level;

  // walk over the window
  logic [LEN_W-1:0]    issue_cnt;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LEN_W+1:0]    third3;             // 3 * (issued index + 1)
  logic                s1_valid, s1_live;
  class_t              s1_cls;
  logic                s2_valid, s2_fifth, s2_neg;
  logic signed [TERM_W-1:0] s2_val;
  logic [PROD_W-1:0]   s2_prod;
  logic signed [ACC_W-1:0]  acc;

  // divider
  logic [LEN_W-1:0]    div_rem;
  logic [ACC_W-1:0]    div_quo;
  logic                div_neg;
  logic [DCNT_W-1:0]   div_cnt;

  // handshake and sequencing strobes
  logic item_accept, cfg_accept;
  logic walk_issue, walk_done, div_step, div_last, out_load;

  // ---------------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    walk_issue    = 1'b0;
    walk_done     = 1'b0;
    div_step      = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        s_axis_tready = !cfg_valid;  // a pending register write goes first
      end
      ST_WALK: begin
        walk_issue = (issue_cnt != window_length);
        walk_done  = (issue_cnt == window_length) && !s1_valid && !s2_valid;
      end
      ST_DIV: begin
        div_step = 1'b1;
      end
      ST_DONE: begin
        out_load = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign item_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_accept  = cfg_valid && cfg_ready;
  assign div_last    = (div_cnt == DCNT_W'(ACC_W - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_accept) state_next = ST_WALK;
      ST_WALK: if (walk_done)   state_next = ST_DIV;
      ST_DIV:  if (div_last)    state_next = ST_DONE;
      ST_DONE: if (out_load)    state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // registers and window bookkeeping
  // ---------------------------------------------------------------------------
  logic                win_full;
  logic [ADDR_W-1:0]   head_wrap, wr_addr, head_after;

  assign win_full   = (fill_count == window_length);
  assign head_wrap  = (LEN_W'(head) == window_length - LEN_W'(1)) ? '0 : head + ADDR_W'(1);
  // while filling, the new sample goes to the next free slot and slot 0 stays oldest;
  // once full it overwrites the oldest slot and the oldest moves up by one
  assign wr_addr    = win_full ? head : fill_count[ADDR_W-1:0];
  assign head_after = win_full ? head_wrap : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_W'(DEF_LEN);
      average_kind  <= KIND_PLAIN;
      fill_count    <= '0;
      head          <= '0;
    end else if (cfg_accept) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        if (cfg_data < LEN_W'(2) || cfg_data > LEN_W'(MAX_WINDOW)) begin
          window_length <= LEN_W'(DEF_LEN);
        end else begin
          window_length <= cfg_data;
        end
        fill_count <= '0;
        head       <= '0;
      end else if (cfg_index == REG_AVERAGE_KIND) begin
        case (cfg_data[1:0])
          2'd1:    average_kind <= KIND_WEIGHTED;
          2'd2:    average_kind <= KIND_DEVIATION;
          default: average_kind <= KIND_PLAIN;  // undefined kind falls back to plain
        endcase
      end
    end else if (item_accept) begin
      head <= head_after;
      if (!win_full) fill_count <= fill_count + LEN_W'(1);
    end
  end

  // sample RAM: written on the accepting cycle, read during the walk
  always_ff @(posedge clk) begin
    if (item_accept) window_store[wr_addr] <= $signed(s_axis_tdata[15:0]);
    if (walk_issue)  mem_rdata <= window_store[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // read issue, oldest entry first
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_accept) begin
      ref_level <= $signed(s_axis_tdata[31:16]);
      issue_cnt <= '0;
      rd_addr   <= head_after;
      third3    <= (LEN_W + 2)'(3);
    end else if (walk_issue) begin
      issue_cnt <= issue_cnt + LEN_W'(1);
      rd_addr   <= (LEN_W'(rd_addr) == window_length - LEN_W'(1)) ? '0
                                                                   : rd_addr + ADDR_W'(1);
      third3    <= third3 + (LEN_W + 2)'(3);
    end
  end

  // index i is in the oldest third when i < L/3, i.e. 3(i+1) <= L; middle when 3(i+1) <= 2L
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= walk_issue;
    end
    if (walk_issue) begin
      s1_live <= (issue_cnt < fill_count);
      if (third3 <= (LEN_W + 2)'(window_length)) begin
        s1_cls <= CLS_HALF;
      end else if (third3 <= (LEN_W + 2)'({window_length, 1'b0})) begin
        s1_cls <= CLS_FIFTH;
      end else begin
        s1_cls <= CLS_FULL;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // per-sample term
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] v, half_tmp, half;
  logic signed [TERM_W-1:0]   diff, term_next;
  logic [TERM_W-1:0]          mag, mag4;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    v         = s1_live ? mem_rdata : '0;  // unfilled slots count as zero
    diff      = TERM_W'(v) - TERM_W'(ref_level);
    half_tmp  = v + $signed({{(SAMPLE_W - 1){1'b0}}, v[SAMPLE_W-1]});
    half      = half_tmp >>> 1;            // toward zero
    mag       = v[SAMPLE_W-1] ? TERM_W'(-TERM_W'(v)) : TERM_W'(v);
    mag4      = mag << 2;
    prod      = mag4 * FIFTH_MUL;
    term_next = TERM_W'(v);
    case (average_kind)
      KIND_DEVIATION: term_next = diff[TERM_W-1] ? -diff : diff;
      KIND_WEIGHTED: begin
        if (s1_cls == CLS_HALF) term_next = TERM_W'(half);
      end
      default: term_next = TERM_W'(v);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_val   <= term_next;
      s2_fifth <= (average_kind == KIND_WEIGHTED) && (s1_cls == CLS_FIFTH);
      s2_neg   <= v[SAMPLE_W-1];
      s2_prod  <= prod;
    end
  end

  // ---------------------------------------------------------------------------
  // accumulate
  // ---------------------------------------------------------------------------
  logic [15:0]              fifth_q;
  logic signed [TERM_W-1:0] fifth_term, term;

  always_comb begin
    fifth_q    = s2_prod[PROD_W-1:FIFTH_SHIFT];
    fifth_term = s2_neg ? -$signed(TERM_W'(fifth_q)) : $signed(TERM_W'(fifth_q));
    term       = s2_fifth ? fifth_term : s2_val;
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(term);
    end
  end

  // ---------------------------------------------------------------------------
  // restoring divide of |sum| by the window length, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [LEN_W:0] trial, trial_sub;
  logic           trial_ge;

  always_comb begin
    trial     = {div_rem, div_quo[ACC_W-1]};
    trial_sub = trial - {1'b0, window_length};
    trial_ge  = (trial >= {1'b0, window_length});
  end

  always_ff @(posedge clk) begin
    if (walk_done) begin
      div_quo <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      div_neg <= acc[ACC_W-1];
      div_rem <= '0;
      div_cnt <= '0;
    end else if (div_step) begin
      div_rem <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
      div_quo <= {div_quo[ACC_W-2:0], trial_ge};
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [15:0] quo16, result;

  always_comb begin
    quo16 = div_quo[15:0];
    if (average_kind == KIND_DEVIATION && div_quo > ACC_W'(SAT_MAX)) begin
      result = SAT_MAX;  // deviation mean beyond 16-bit range saturates
    end else begin
      result = div_neg ? -quo16 : quo16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) m_axis_tdata <= result;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import waf_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int CFG_DATA_W   = $clog2(MAX_LEN + 1);
  localparam int MIN_LEN      = 2;
  localparam int DEF_LEN      = (DEF_LEN_REQ <= MAX_LEN) ? DEF_LEN_REQ : MAX_LEN;
  // worst item latency at full length plus margin
  localparam int DRAIN_CYCLES = MAX_LEN + 18 + $clog2(MAX_LEN) + 5 + 40;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 24;
  localparam int PHASE_ITEMS  = 46;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST  = 8'hFF;

  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata;   // [15:0] sample, [31:16] reference
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;   // [15:0] average
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state
  logic signed [15:0] window_q [MAX_LEN];
  int                 fill_count;
  int                 win_len;
  kind_t              avg_kind;

  logic [15:0] expected_averages [$];
  logic [15:0] next_average;
  int          errors;
  int          cycle_count;
  int          hold_off_left;
  bit          no_idle;

  windowed_average_filter #(
    .MAX_WINDOW(MAX_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_WINDOW_LENGTH) begin
      if (val < MIN_LEN || val > MAX_LEN) win_len = DEF_LEN;
      else win_len = int'(val);
      foreach (window_q[i]) window_q[i] = '0;
      fill_count = 0;
    end else if (idx == REG_AVERAGE_KIND) begin
      avg_kind = (val[1:0] == KIND_UNUSED) ? KIND_PLAIN : kind_t'(val[1:0]);
    end
  endfunction

  // shifts the sample into the window and returns the average it produces
  function automatic logic [15:0] window_average(input logic signed [15:0] smp,
                                                 input logic signed [15:0] lvl);
    int total;
    int v;
    int third;
    int two_thirds;
    int res;
    total      = 0;
    third      = win_len / 3;
    two_thirds = (win_len * 2) / 3;
    if (fill_count < win_len) begin
      window_q[fill_count] = smp;
      fill_count++;
    end else begin
      for (int i = 0; i + 1 < win_len; i++) window_q[i] = window_q[i + 1];
      window_q[win_len - 1] = smp;
    end
    for (int i = 0; i < win_len; i++) begin
      v = int'(window_q[i]);
      case (avg_kind)
        KIND_WEIGHTED: begin
          if (i < third) total += v / 2;
          else if (i < two_thirds) total += (v * 4) / 5;
          else total += v;
        end
        KIND_DEVIATION: total += (v > lvl) ? v - lvl : lvl - v;
        default: total += v;
      endcase
    end
    res = total / win_len;
    if (avg_kind == KIND_DEVIATION && res > SAT_MAX) res = SAT_MAX;
    return res[15:0];
  endfunction

  function automatic logic signed [15:0] pick_value();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: return S_MAX;
        1: return S_MIN;
        2: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return CFG_DATA_W'($urandom_range(12, MIN_LEN));
    else if (roll < 78) return CFG_DATA_W'($urandom_range(40, 13));
    else if (roll < 90) return CFG_DATA_W'(MAX_LEN - $urandom_range(1, 0));
    return CFG_DATA_W'($urandom_range(2 ** CFG_DATA_W - 1, 0));
  endfunction

  task automatic wait_for_averages();
    while (expected_averages.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // called and returns at a falling edge
  task automatic send_sample(input logic signed [15:0] smp, input logic signed [15:0] lvl);
    int gap;
    if (!no_idle) begin
      gap = 0;
      if ($urandom_range(99) < 3) gap = $urandom_range(120, 1);
      while ($urandom_range(99) < IDLE_PCT) gap++;
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    expected_averages.push_back(window_average(smp, lvl));
    s_axis_tdata  = {lvl, smp};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_for_averages();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // default length and plain mean straight out of reset, window still filling
  task automatic test_reset_state();
    send_sample(S_MAX, 16'sd0);
    send_sample(S_MAX, 16'sd0);
    send_sample(S_MIN, S_MAX);
    send_sample(-16'sd1, S_MIN);
  endtask

  task automatic test_length_limits();
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(MIN_LEN));
    repeat (3) send_sample(S_MAX, 16'sd0);
    repeat (2) send_sample(S_MIN, 16'sd0);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(MAX_LEN));
    send_sample(S_MIN, 16'sd0);
    send_sample(S_MAX, 16'sd0);
    // out of range lengths fall back to the default
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(0));
    send_sample(16'sd100, 16'sd0);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
    send_sample(-16'sd100, 16'sd0);
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(MAX_LEN + 1));
    send_sample(S_MIN, 16'sd0);
    write_register(REG_WINDOW_LENGTH, '1);
    send_sample(S_MAX, 16'sd0);
  endtask

  task automatic test_kinds();
    // negative terms truncate toward zero in the halved and the 4/5 thirds
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
    write_register(REG_AVERAGE_KIND, CFG_DATA_W'(KIND_WEIGHTED));
    send_sample(-16'sd5, 16'sd0);
    send_sample(16'sd7, 16'sd0);
    send_sample(-16'sd9, 16'sd0);
    send_sample(S_MIN, 16'sd0);
    // deviation past the 16-bit range saturates
    write_register(REG_AVERAGE_KIND, CFG_DATA_W'(KIND_DEVIATION));
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(MIN_LEN));
    send_sample(S_MIN, S_MAX);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MIN);
    // unused kind code reads as plain, window kept
    write_register(REG_AVERAGE_KIND, CFG_DATA_W'(KIND_UNUSED));
    send_sample(16'sd3, S_MAX);
    // writes to unmapped indexes change nothing
    write_register(REG_SPARE, CFG_DATA_W'(5));
    write_register(REG_LAST, '1);
    send_sample(-16'sd3, S_MIN);
  endtask

  // receiver holds off long enough that the input side stalls, then the sender drains
  task automatic test_backpressure();
    write_register(REG_WINDOW_LENGTH, CFG_DATA_W'(16));
    no_idle = 1'b1;
    @(posedge clk);
    hold_off_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (8) send_sample(pick_value(), pick_value());
    no_idle = 1'b0;
    wait_for_averages();
    repeat (4) send_sample(pick_value(), pick_value());
  endtask

  task automatic test_random();
    for (int phase = 0; phase < PHASES; phase++) begin
      // every fourth phase keeps the window running across the kind change
      if (phase % 4 != 3) write_register(REG_WINDOW_LENGTH, pick_length());
      write_register(REG_AVERAGE_KIND, CFG_DATA_W'($urandom_range(2 ** CFG_DATA_W - 1, 0)));
      if ($urandom_range(99) < 20)
        write_register(CFG_INDEX_W'($urandom_range(REG_LAST, REG_SPARE)),
                       CFG_DATA_W'($urandom));
      no_idle = (phase == 6);
      repeat (PHASE_ITEMS) send_sample(pick_value(), pick_value());
    end
    no_idle = 1'b0;
  endtask

  // receiver side ready, with random stalls and an optional hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        m_axis_tready = 1'b0;
        hold_off_left--;
      end else if (no_idle) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected average, expected none, actual %0d",
                 $time, $signed(m_axis_tdata));
      end else begin
        next_average = expected_averages.pop_front();
        if (m_axis_tdata !== next_average) begin
          errors++;
          $display("%0t: average mismatch, expected %0d, actual %0d",
                   $time, $signed(next_average), $signed(m_axis_tdata));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    errors        = 0;
    hold_off_left = 0;
    no_idle       = 1'b0;
    win_len       = DEF_LEN;
    fill_count    = 0;
    avg_kind      = KIND_PLAIN;
    foreach (window_q[i]) window_q[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_length_limits();
    test_kinds();
    test_backpressure();
    test_random();

    wait_for_averages();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
